[design/lc3_pkg.sv]
// Package for the LC-3 instruction step block: widths, item and result types,
// ISA opcodes, condition codes and small decode helpers.
// Used by every module in the design folder but lc3_ram.
package lc3_pkg;

  localparam int ADDR_WIDTH  = 16;
  localparam int WORD_W      = 16;
  localparam int MEM_DEPTH   = 1 << ADDR_WIDTH;
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int COND_W      = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [ADDR_WIDTH-1:0] maddr_t;
  typedef logic [REG_IDX_W-1:0]  ridx_t;
  typedef logic [COND_W-1:0]     cond_t;

  localparam word_t PC_RESET = 16'h3000;

  // condition codes, one-hot
  localparam cond_t COND_P = 3'b001;
  localparam cond_t COND_Z = 3'b010;
  localparam cond_t COND_N = 3'b100;

  localparam ridx_t LINK_REG = ridx_t'(NUM_REGS - 1);

  // ISA opcodes (instruction bits 15:12)
  localparam logic [3:0] OP_BR  = 4'h0;
  localparam logic [3:0] OP_ADD = 4'h1;
  localparam logic [3:0] OP_LD  = 4'h2;
  localparam logic [3:0] OP_JSR = 4'h4;
  localparam logic [3:0] OP_AND = 4'h5;
  localparam logic [3:0] OP_NOT = 4'h9;
  localparam logic [3:0] OP_LDI = 4'hA;
  localparam logic [3:0] OP_JMP = 4'hC;

  // kind of stream word, carried on tuser
  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_EXEC    = 2'd2,
    KIND_NOP     = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    word_t address;
    word_t data;
  } item_t;

  // result word, pc in the lowest bits
  typedef struct packed {
    logic  not_executed;
    word_t reg_value;
    ridx_t reg_index;
    logic  reg_write;
    cond_t flags;
    word_t instruction;
    word_t pc;
  } result_t;

  function automatic word_t sext5(input logic [4:0] v);
    sext5 = {{(WORD_W-5){v[4]}}, v};
  endfunction

  function automatic word_t sext9(input logic [8:0] v);
    sext9 = {{(WORD_W-9){v[8]}}, v};
  endfunction

  function automatic word_t sext11(input logic [10:0] v);
    sext11 = {{(WORD_W-11){v[10]}}, v};
  endfunction

  function automatic cond_t cond_of(input word_t v);
    if (v == '0) begin
      cond_of = COND_Z;
    end else if (v[WORD_W-1]) begin
      cond_of = COND_N;
    end else begin
      cond_of = COND_P;
    end
  endfunction

endpackage

[design/lc3_instruction_step.sv]
// Write, restart and ignored words pass the queue and the result register;
// instructions also pass fetch, ST_DEC and ST_EXEC (LDI: ST_IND) between.
// Throughput: 1 non-instruction word per cycle while the result register is
// free; one instruction at a time, as the sequencer shares one read port.
// Reset (rst, synchronous): PC 0x3000, flag Z, registers read as zero,
// start address 0x3000, queue and result register empty; memory is kept.
module lc3_instruction_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        start_address_wr_en,
  input  logic [15:0] start_address,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] address, [31:16] data
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] pc, [31:16] instruction, [34:32] flags, [35] reg_write,
  // [38:36] reg_index, [54:39] reg_value, [55] not_executed
  output logic [55:0] m_axis_tdata
);
  import lc3_pkg::*;

  logic    q_valid;
  logic    q_ready;
  item_t   q_item;
  result_t result;

  lc3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .s_opcode  (s_axis_tuser),
    .s_address (s_axis_tdata[15:0]),
    .s_data    (s_axis_tdata[31:16]),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  lc3_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (start_address_wr_en),
    .cfg_data (start_address),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_result (result)
  );

  assign m_axis_tdata = result;

endmodule

[design/lc3_ram.sv]
// Generic RAM: one write port, one read port with registered read data.
// No dependencies.
module lc3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then registered read; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/lc3_front.sv]
// Front part: accepts stream words, classifies them by kind and queues them.
// Depends on lc3_pkg.
module lc3_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_valid,
  output logic          s_ready,
  input  logic [1:0]    s_opcode,
  input  lc3_pkg::word_t s_address,
  input  lc3_pkg::word_t s_data,
  output logic          q_valid,
  input  logic          q_ready,
  output lc3_pkg::item_t q_item
);
  import lc3_pkg::*;

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;
  item_t             item_in;

  assign s_ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];
  assign push    = s_valid && s_ready;
  assign pop     = q_valid && q_ready;

  // classify the incoming word
  always_comb begin
    item_in.kind    = kind_t'(s_opcode);
    item_in.address = s_address;
    item_in.data    = s_data;
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // store the word
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

endmodule

[design/lc3_back.sv]
// Back part: sequencer that carries out queued words against the word memory,
// the register file and the PC/condition state; holds the result register.
// Depends on lc3_pkg and lc3_ram.
module lc3_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  lc3_pkg::word_t  cfg_data,
  input  logic            q_valid,
  output logic            q_ready,
  input  lc3_pkg::item_t  q_item,
  output logic            m_valid,
  input  logic            m_ready,
  output lc3_pkg::result_t m_result
);
  import lc3_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DEC  = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_IND  = 4'b1000
  } state_t;

  state_t  state, state_next;
  word_t   pc;
  word_t   start_addr;
  cond_t   cond;
  word_t   instr;
  result_t out_q;
  logic    out_valid;
  logic [NUM_REGS-1:0] reg_valid;
  logic    rv1, rv2;

  logic    mem_we, mem_re;
  maddr_t  mem_waddr, mem_raddr;
  word_t   mem_wdata, mem_rdata;

  logic    rf_re, rf_we;
  ridx_t   rf_ra1, rf_ra2, rf_wa;
  word_t   rf_rd1, rf_rd2, rf_wd;

  logic    out_free, fin, wr, set_cond;
  logic [3:0] op;
  ridx_t   dr;
  word_t   src_a, src_b, op_b, pc_inc, pc_new, wval, dec_addr;
  cond_t   cond_new;
  result_t res;

  assign out_free = !out_valid || m_ready;
  assign m_valid  = out_valid;
  assign m_result = out_q;

  assign op     = instr[15:12];
  assign dr     = instr[11:9];
  assign src_a  = rv1 ? rf_rd1 : '0;
  assign src_b  = rv2 ? rf_rd2 : '0;
  assign pc_inc = pc + 16'd1;
  assign op_b   = instr[5] ? sext5(instr[4:0]) : src_b;

  // register operands come from the fetched word
  assign rf_ra1 = mem_rdata[8:6];
  assign rf_ra2 = mem_rdata[2:0];

  // sequence one word
  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = q_item.address[ADDR_WIDTH-1:0];
    mem_wdata  = q_item.data;
    mem_raddr  = pc[ADDR_WIDTH-1:0];
    rf_re      = 1'b0;
    fin        = 1'b0;
    wr         = 1'b0;
    set_cond   = 1'b0;
    rf_wa      = dr;
    wval       = '0;
    pc_new     = pc;
    cond_new   = cond;
    dec_addr   = pc_inc + sext9(mem_rdata[8:0]);
    res        = '0;

    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_item.kind)
            KIND_EXEC: begin
              q_ready    = 1'b1;
              mem_re     = 1'b1;
              state_next = ST_DEC;
            end
            KIND_WRITE: begin
              if (out_free) begin
                q_ready = 1'b1;
                mem_we  = 1'b1;
                fin     = 1'b1;
              end
            end
            KIND_RESTART: begin
              if (out_free) begin
                q_ready  = 1'b1;
                fin      = 1'b1;
                pc_new   = start_addr;
                cond_new = COND_Z;
              end
            end
            KIND_NOP: begin
              if (out_free) begin
                q_ready = 1'b1;
                fin     = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DEC: begin
        // read operands and the load address in parallel
        rf_re      = 1'b1;
        mem_re     = 1'b1;
        mem_raddr  = dec_addr[ADDR_WIDTH-1:0];
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        res.instruction = instr;
        pc_new          = pc_inc;
        unique case (op) inside
          OP_ADD, OP_AND: begin
            wr       = 1'b1;
            set_cond = 1'b1;
            wval     = (op == OP_ADD) ? src_a + op_b : src_a & op_b;
          end
          OP_NOT: begin
            wr       = 1'b1;
            set_cond = 1'b1;
            wval     = ~src_a;
          end
          OP_BR: begin
            if ((instr[11:9] & cond) != '0) begin
              pc_new = pc_inc + sext9(instr[8:0]);
            end
          end
          OP_JMP: begin
            pc_new = src_a;
          end
          OP_JSR: begin
            wr     = 1'b1;
            rf_wa  = LINK_REG;
            wval   = pc_inc;
            pc_new = instr[11] ? pc_inc + sext11(instr[10:0]) : src_a;
          end
          OP_LD: begin
            wr       = 1'b1;
            set_cond = 1'b1;
            wval     = mem_rdata;
          end
          OP_LDI: begin
            mem_re    = 1'b1;
            mem_raddr = mem_rdata[ADDR_WIDTH-1:0];
          end
          default: begin
            res.not_executed = 1'b1;
          end
        endcase
        if (op == OP_LDI) begin
          state_next = ST_IND;
        end else if (out_free) begin
          fin        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_IND: begin
        res.instruction = instr;
        pc_new          = pc_inc;
        wr              = 1'b1;
        set_cond        = 1'b1;
        wval            = mem_rdata;
        if (out_free) begin
          fin        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (wr && set_cond) begin
      cond_new = cond_of(wval);
    end
    if (wr) begin
      res.reg_write = 1'b1;
      res.reg_index = rf_wa;
      res.reg_value = wval;
    end
    res.pc    = pc_new;
    res.flags = cond_new;
  end

  assign rf_we = fin && wr;
  assign rf_wd = wval;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pc         <= PC_RESET;
      cond       <= COND_Z;
      start_addr <= PC_RESET;
      out_valid  <= 1'b0;
      reg_valid  <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        start_addr <= cfg_data;
      end
      if (fin) begin
        pc        <= pc_new;
        cond      <= cond_new;
        out_valid <= 1'b1;
      end else if (m_ready) begin
        out_valid <= 1'b0;
      end
      if (rf_we) begin
        reg_valid[rf_wa] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (fin) begin
      out_q <= res;
    end
    if (state == ST_DEC) begin
      instr <= mem_rdata;
    end
    if (rf_re) begin
      rv1 <= reg_valid[rf_ra1];
      rv2 <= reg_valid[rf_ra2];
    end
  end

  // word memory
  lc3_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // register file, one copy per read port
  lc3_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_wa),
    .wdata (rf_wd),
    .re    (rf_re),
    .raddr (rf_ra1),
    .rdata (rf_rd1)
  );

  lc3_ram #(.WIDTH(WORD_W), .DEPTH(NUM_REGS)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_wa),
    .wdata (rf_wd),
    .re    (rf_re),
    .raddr (rf_ra2),
    .rdata (rf_rd2)
  );

endmodule

[design/lc3_checker.sv]
// Port-level checker for lc3_instruction_step, attached by bind.
// Depends on lc3_pkg.
module lc3_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);
  import lc3_pkg::*;

  // empty output and open input right after reset
  a_reset_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");
  a_reset_in: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready after reset");

  // hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // condition flags stay one-hot
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot(m_axis_tdata[34:32]))
    else $error("flags not one-hot");

  // no register write leaves index and value clear; JSR links through R7
  a_regwr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[35] || m_axis_tdata[54:36] == '0) &&
      (!m_axis_tdata[35] || m_axis_tdata[31:28] != OP_JSR ||
       m_axis_tdata[38:36] == LINK_REG))
    else $error("register write fields inconsistent");

endmodule

bind lc3_instruction_step lc3_checker u_lc3_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[verif/tb_top.sv]
// Self-checking bench for lc3_instruction_step: a stream of memory writes,
// restarts and instruction steps, checked against an in-bench model of the core.
// Depends on lc3_pkg and lc3_instruction_step from the design folder.
`timescale 1ns / 1ps

module tb_top;
  import lc3_pkg::*;

  // instruction opcodes outside the executed subset
  localparam logic [3:0] OP_ST   = 4'h3;
  localparam logic [3:0] OP_LDR  = 4'h6;
  localparam logic [3:0] OP_STR  = 4'h7;
  localparam logic [3:0] OP_RTI  = 4'h8;
  localparam logic [3:0] OP_STI  = 4'hB;
  localparam logic [3:0] OP_RSV  = 4'hD;
  localparam logic [3:0] OP_LEA  = 4'hE;
  localparam logic [3:0] OP_TRAP = 4'hF;

  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 215;

  typedef struct packed {
    kind_t kind;
    word_t address;
    word_t data;
    bit    typed;
    word_t pc;
    word_t instruction;
    cond_t flags;
    bit    not_executed;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start_address_wr_en = 1'b0;
  logic [15:0] start_address = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  // architectural state as the bench sees it
  word_t core_regs [NUM_REGS];
  word_t core_pc;
  cond_t core_cond;
  word_t core_start;
  word_t core_mem [0:MEM_DEPTH-1];
  bit    core_written [0:MEM_DEPTH-1];

  result_t   pending_results [$];
  step_row_t directed_steps [$];
  int        burst_left = 0;
  int        items_sent = 0;
  int        mismatches = 0;

  lc3_instruction_step i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .start_address_wr_en (start_address_wr_en),
    .start_address       (start_address),
    .s_axis_tvalid       (s_axis_tvalid),
    .s_axis_tready       (s_axis_tready),
    .s_axis_tdata        (s_axis_tdata),   // [15:0] address, [31:16] data
    .s_axis_tuser        (s_axis_tuser),   // [1:0] opcode
    .m_axis_tvalid       (m_axis_tvalid),
    .m_axis_tready       (m_axis_tready),
    // [15:0] pc, [31:16] instruction, [34:32] flags, [35] reg_write,
    // [38:36] reg_index, [54:39] reg_value, [55] not_executed
    .m_axis_tdata        (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic word_t sx9(input word_t ins);
    return {{7{ins[8]}}, ins[8:0]};
  endfunction

  // Advance the core by one word and return the result it reports.
  function automatic result_t core_step(input kind_t k, input word_t a, input word_t d);
    result_t    r;
    word_t      ins;
    word_t      src2;
    word_t      ea;
    logic [3:0] op;
    ridx_t      dr;
    ridx_t      sr1;
    r = '0;
    case (k)
      KIND_WRITE: begin
        core_mem[a] = d;
        core_written[a] = 1'b1;
      end
      KIND_RESTART: begin
        core_pc = core_start;
        core_cond = COND_Z;
      end
      KIND_EXEC: begin
        ins = core_mem[core_pc];
        core_pc = core_pc + 16'd1;
        op = ins[15:12];
        dr = ins[11:9];
        sr1 = ins[8:6];
        ea = core_pc + sx9(ins);
        r.instruction = ins;
        case (op)
          OP_ADD, OP_AND: begin
            src2 = ins[5] ? {{11{ins[4]}}, ins[4:0]} : core_regs[ins[2:0]];
            r.reg_value = (op == OP_ADD) ? core_regs[sr1] + src2 : core_regs[sr1] & src2;
            r.reg_write = 1'b1;
            r.reg_index = dr;
          end
          OP_NOT: begin
            r.reg_value = ~core_regs[sr1];
            r.reg_write = 1'b1;
            r.reg_index = dr;
          end
          OP_BR: begin
            if ((ins[11:9] & core_cond) != '0) core_pc = ea;
          end
          OP_JMP: begin
            core_pc = core_regs[sr1];
          end
          OP_JSR: begin
            // link is the incremented PC; JSRR R7 jumps through the old R7
            r.reg_value = core_pc;
            core_pc = ins[11] ? core_pc + {{5{ins[10]}}, ins[10:0]} : core_regs[sr1];
            r.reg_write = 1'b1;
            r.reg_index = LINK_REG;
          end
          OP_LD: begin
            r.reg_value = core_mem[ea];
            r.reg_write = 1'b1;
            r.reg_index = dr;
          end
          OP_LDI: begin
            r.reg_value = core_mem[core_mem[ea]];
            r.reg_write = 1'b1;
            r.reg_index = dr;
          end
          default: begin
            r.not_executed = 1'b1;
          end
        endcase
        if (r.reg_write) begin
          core_regs[r.reg_index] = r.reg_value;
          if (op != OP_JSR) begin
            core_cond = (r.reg_value == '0) ? COND_Z : (r.reg_value[15] ? COND_N : COND_P);
          end
        end
      end
      default: ;
    endcase
    r.pc = core_pc;
    r.flags = core_cond;
    return r;
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic word_t rand_instr();
    logic [3:0] op;
    case ($urandom_range(0, 29))
      0, 1, 2:    op = OP_ADD;
      3, 4, 5:    op = OP_AND;
      6, 7:       op = OP_NOT;
      8, 9, 10:   op = OP_BR;
      11, 12:     op = OP_JMP;
      13, 14, 15: op = OP_JSR;
      16, 17, 18: op = OP_LD;
      19, 20, 21: op = OP_LDI;
      22:         op = OP_ST;
      23:         op = OP_LDR;
      24:         op = OP_STR;
      25:         op = OP_RTI;
      26:         op = OP_STI;
      27:         op = OP_RSV;
      28:         op = OP_LEA;
      default:    op = OP_TRAP;
    endcase
    return {op, 12'($urandom_range(0, 4095))};
  endfunction

  // Drive one word in bursts, wait for acceptance, then queue its result.
  task automatic send_step(input kind_t k, input word_t a, input word_t d,
                           input bit typed, input result_t typed_res);
    int      gap;
    result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left = burst_left - 1;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {d, a};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    r = core_step(k, a, d);
    pending_results.push_back(typed ? typed_res : r);
    if (k != KIND_NOP) items_sent++;
    @(negedge clk);
  endtask

  // Run one instruction, first loading any word it would read.
  task automatic exec_one();
    word_t ins;
    word_t ea;
    word_t ptr;
    if (!core_written[core_pc]) send_step(KIND_WRITE, core_pc, rand_instr(), 1'b0, '0);
    ins = core_mem[core_pc];
    if (ins[15:12] == OP_LD || ins[15:12] == OP_LDI) begin
      ea = core_pc + 16'd1 + sx9(ins);
      if (!core_written[ea]) send_step(KIND_WRITE, ea, pick_word(), 1'b0, '0);
      if (ins[15:12] == OP_LDI) begin
        ptr = core_mem[ea];
        if (!core_written[ptr]) send_step(KIND_WRITE, ptr, pick_word(), 1'b0, '0);
      end
    end
    send_step(KIND_EXEC, word_t'($urandom), word_t'($urandom), 1'b0, '0);
  endtask

  // Drain, let the pipeline settle, then write the start address.
  task automatic set_start(input word_t v);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
    start_address_wr_en <= 1'b1;
    start_address       <= v;
    @(negedge clk);
    start_address_wr_en <= 1'b0;
    core_start = v;
    burst_left = 0;
  endtask

  task automatic add_row(input kind_t k, input word_t a, input word_t d, input bit typed,
                         input word_t pc, input word_t ins, input cond_t fl, input bit nx);
    directed_steps.push_back('{k, a, d, typed, pc, ins, fl, nx});
  endtask

  // Receiver: stall in randomly changing modes
  int unsigned stall_mode = 0;
  int unsigned stall_cnt  = 0;
  logic [1:0]  stall_phase = '0;

  always @(negedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_cnt  <= $urandom_range(20, 80);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (stall_phase == 2'd0);
      default: m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
    stall_phase <= stall_phase + 2'd1;
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (pending_results.size() == 0) begin
        if (mismatches < 10) $display("unexpected result word %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.pc !== want.pc || got.instruction !== want.instruction ||
            got.flags !== want.flags || got.reg_write !== want.reg_write ||
            got.reg_index !== want.reg_index || got.reg_value !== want.reg_value ||
            got.not_executed !== want.not_executed) begin
          if (mismatches < 10) begin
            $display("mismatch exp: pc %h ins %h fl %b wr %b idx %0d val %h nx %b",
                     want.pc, want.instruction, want.flags, want.reg_write,
                     want.reg_index, want.reg_value, want.not_executed);
            $display("         got: pc %h ins %h fl %b wr %b idx %0d val %h nx %b",
                     got.pc, got.instruction, got.flags, got.reg_write,
                     got.reg_index, got.reg_value, got.not_executed);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    step_row_t row;
    result_t   typed_res;
    word_t     start_val;
    int        phase_end;
    int        sel;

    for (int i = 0; i < NUM_REGS; i++) core_regs[i] = '0;
    core_pc    = PC_RESET;
    core_cond  = COND_Z;
    core_start = PC_RESET;

    // after reset, address extremes, then a short program
    add_row(KIND_NOP,   16'hFFFF, 16'hFFFF, 1'b1, PC_RESET, '0, COND_Z, 1'b0);
    add_row(KIND_WRITE, 16'hFFFF, 16'hFFFF, 1'b1, PC_RESET, '0, COND_Z, 1'b0);
    add_row(KIND_WRITE, 16'h0000, 16'h0000, 1'b1, PC_RESET, '0, COND_Z, 1'b0);
    add_row(KIND_WRITE, 16'h3000, 16'h127F, 1'b1, PC_RESET, '0, COND_Z, 1'b0); // ADD R1,R1,#-1
    add_row(KIND_WRITE, 16'h3001, 16'h947F, 1'b1, PC_RESET, '0, COND_Z, 1'b0); // NOT R2,R1
    add_row(KIND_WRITE, 16'h3002, 16'h166F, 1'b1, PC_RESET, '0, COND_Z, 1'b0); // ADD R3,R1,#15
    add_row(KIND_WRITE, 16'h3003, 16'h58C1, 1'b1, PC_RESET, '0, COND_Z, 1'b0); // AND R4,R3,R1
    add_row(KIND_WRITE, 16'h3004, 16'h2A03, 1'b1, PC_RESET, '0, COND_Z, 1'b0); // LD R5
    add_row(KIND_WRITE, 16'h3005, 16'hAC03, 1'b1, PC_RESET, '0, COND_Z, 1'b0); // LDI R6
    add_row(KIND_WRITE, 16'h3006, 16'h0000, 1'b1, PC_RESET, '0, COND_Z, 1'b0); // BR, no nzp
    add_row(KIND_WRITE, 16'h3007, 16'h4803, 1'b1, PC_RESET, '0, COND_Z, 1'b0); // JSR +3
    add_row(KIND_WRITE, 16'h3008, 16'h7FFF, 1'b1, PC_RESET, '0, COND_Z, 1'b0);
    add_row(KIND_WRITE, 16'h3009, 16'h300A, 1'b1, PC_RESET, '0, COND_Z, 1'b0);
    add_row(KIND_WRITE, 16'h300A, 16'h8000, 1'b1, PC_RESET, '0, COND_Z, 1'b0);
    add_row(KIND_WRITE, 16'h300B, 16'h41C0, 1'b1, PC_RESET, '0, COND_Z, 1'b0); // JSRR R7
    for (int i = 0; i < 9; i++) begin
      add_row(KIND_EXEC, 16'hA5A5 ^ 16'(i), 16'h5A5A, 1'b0, '0, '0, '0, 1'b0);
    end
    // JSRR through R7 lands on an unimplemented opcode word
    add_row(KIND_EXEC,    16'h0000, 16'hFFFF, 1'b1, 16'h3009, 16'h7FFF, COND_N, 1'b1);
    add_row(KIND_RESTART, 16'hFFFF, 16'h0000, 1'b1, PC_RESET, '0, COND_Z, 1'b0);

    // hold reset, then release it on a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (2) @(negedge clk);

    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      typed_res = '0;
      typed_res.pc = row.pc;
      typed_res.instruction = row.instruction;
      typed_res.flags = row.flags;
      typed_res.not_executed = row.not_executed;
      send_step(row.kind, row.address, row.data, row.typed, typed_res);
    end

    // random phases, each under its own start address
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: start_val = 16'h0000;
        1: start_val = 16'hFFFF;
        3: start_val = PC_RESET;
        default: start_val = word_t'($urandom);
      endcase
      set_start(start_val);
      send_step(KIND_RESTART, word_t'($urandom), word_t'($urandom), 1'b0, '0);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        sel = $urandom_range(0, 99);
        if (sel < 82) begin
          exec_one();
        end else if (sel < 90) begin
          send_step(KIND_WRITE, word_t'($urandom), pick_word(), 1'b0, '0);
        end else if (sel < 95) begin
          send_step(KIND_RESTART, word_t'($urandom), word_t'($urandom), 1'b0, '0);
        end else begin
          send_step(KIND_NOP, word_t'($urandom), word_t'($urandom), 1'b0, '0);
        end
      end
    end

    // drain and let the pipeline settle
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
